/* design/dgs_pkg.sv */
package dgs_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int MEM_DEPTH   = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;
  localparam int CELL_W = 8;
  localparam int CARRY_W = 2;
  // five cells of 255 plus a carry of 3
  localparam int SUM_W  = 11;
  localparam int CELL_MAX = 255;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int TAP_W = 3;
  localparam logic [TAP_W-1:0] TAP_C = 3'd0;
  localparam logic [TAP_W-1:0] TAP_W_ = 3'd1;
  localparam logic [TAP_W-1:0] TAP_E = 3'd2;
  localparam logic [TAP_W-1:0] TAP_N = 3'd3;
  localparam logic [TAP_W-1:0] TAP_S = 3'd4;
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_S;

  typedef struct packed {
    logic             start_read;
    logic             write_en;
    logic             clear_carry;
    logic             issue;
    logic [TAP_W-1:0] tap;
    logic             finish;
  } dgs_cmd_t;

  typedef struct packed {
    logic out_full;
  } dgs_status_t;

endpackage

/* design/dithered_grid_smoothing_core.sv */
// five-point smoothing over a 64 x 64 grid of 8-bit cells
//
// input channel (in_valid / in_ready) carries one word: opcode, col, row,
// cell_value. write stores cell_value, read returns one smoothed word on
// the output channel, clear zeroes the dither carry, opcode three is dropped
// config channel (cfg_valid / cfg_ready) sets dither_enable; always ready,
// write it only while the block is idle
// write, clear and unused opcodes leave the block idle, so they can
// stream back to back. a read walks the center and four neighbors through
// the single-port grid memory, one cell per cycle, then a finishing state
// registers the smoothed word and raises out_valid; the next word is taken
// once the block is back in idle (accept, five memory reads, finish)
// the smoothed word sits in an output register; a stalled receiver holds it
// there, a following write or clear is still taken, and only the finishing
// cycle of the next read waits for the register to empty
// reset clears the control state, the carry and dither_enable; grid cells
// hold garbage until written and need no clearing pass
module dithered_grid_smoothing_core import dgs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [COL_W-1:0]  col,
  input  logic [ROW_W-1:0]  row,
  input  logic [CELL_W-1:0] cell_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] smoothed,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              dither_enable
);

  dgs_cmd_t    cmd;
  dgs_status_t status;

  // config register lives in the datapath and never stalls
  assign cfg_ready = 1'b1;

  // sequencer: accepts words, steps the five taps, waits on the output register
  dgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  // grid memory, tap addressing, accumulator, carry and output register
  dgs_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .col        (col),
    .row        (row),
    .cell_value (cell_value),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (dither_enable),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .smoothed   (smoothed)
  );

endmodule

/* design/dgs_ctrl.sv */
module dgs_ctrl import dgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  dgs_status_t status,
  output dgs_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [TAP_W-1:0] tap;
  logic [TAP_W-1:0] tap_next;
  logic             accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    tap_next   = tap;
    cmd        = '0;
    cmd.tap    = tap;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_WRITE: cmd.write_en = 1'b1;
            OP_READ: begin
              cmd.start_read = 1'b1;
              tap_next       = TAP_C;
              state_next     = ST_READ;
            end
            OP_CLEAR: cmd.clear_carry = 1'b1;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.issue = 1'b1;
        tap_next  = tap + TAP_W'(1);
        if (tap == TAP_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= TAP_C;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

endmodule

/* design/dgs_datapath.sv */
module dgs_datapath import dgs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dgs_cmd_t          cmd,
  output dgs_status_t       status,
  input  logic [COL_W-1:0]  col,
  input  logic [ROW_W-1:0]  row,
  input  logic [CELL_W-1:0] cell_value,
  input  logic              cfg_write,
  input  logic              cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] smoothed
);

  logic [CELL_W-1:0] mem [MEM_DEPTH];
  logic [CELL_W-1:0] rdata;

  logic                dither_mode;
  logic [CARRY_W-1:0]  carry;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic                outside_q;
  logic [SUM_W-1:0]    acc;
  logic                acc_en;

  logic                in_inside;
  logic [ADDR_W-1:0]   in_addr;
  logic [COL_W-1:0]    tap_col;
  logic [ROW_W-1:0]    tap_row;
  logic                tap_use;
  logic [ADDR_W-1:0]   tap_addr;
  logic                has_w;
  logic                has_e;
  logic                has_n;
  logic                has_s;
  logic [SUM_W-1:0]    sum_total;
  logic [SUM_W-3:0]    shifted;
  logic [CELL_W-1:0]   result;

  assign in_inside = (int'(col) < GRID_WIDTH) && (int'(row) < GRID_HEIGHT);
  assign in_addr   = ADDR_W'(int'(row) * GRID_WIDTH + int'(col));

  assign has_w = (col_q != '0);
  assign has_e = (int'(col_q) + 1) < GRID_WIDTH;
  assign has_n = (row_q != '0);
  assign has_s = (int'(row_q) + 1) < GRID_HEIGHT;

  // neighbor select; a missing edge cell drops out or falls back to the center
  always_comb begin
    tap_col = col_q;
    tap_row = row_q;
    tap_use = !outside_q;
    case (cmd.tap)
      TAP_C: ;
      TAP_W_: begin
        if (has_w) tap_col = col_q - COL_W'(1);
        else tap_use = tap_use && dither_mode;
      end
      TAP_E: begin
        if (has_e) tap_col = col_q + COL_W'(1);
        else tap_use = tap_use && dither_mode;
      end
      TAP_N: begin
        if (has_n) tap_row = row_q - ROW_W'(1);
        else tap_use = tap_use && dither_mode;
      end
      TAP_S: begin
        if (has_s) tap_row = row_q + ROW_W'(1);
        else tap_use = tap_use && dither_mode;
      end
      default: tap_use = 1'b0;
    endcase
  end

  assign tap_addr = ADDR_W'(int'(tap_row) * GRID_WIDTH + int'(tap_col));

  always_ff @(posedge clk) begin
    if (cmd.write_en && in_inside) begin
      mem[in_addr] <= cell_value;
    end
    if (cmd.issue) begin
      rdata <= mem[tap_addr];
    end
  end

  assign sum_total = acc + (acc_en ? SUM_W'(rdata) : SUM_W'(0));
  assign shifted   = sum_total[SUM_W-1:2];
  assign result    = outside_q ? CELL_W'(0)
                   : (int'(shifted) > CELL_MAX) ? CELL_W'(CELL_MAX)
                   : shifted[CELL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start_read) begin
      col_q     <= col;
      row_q     <= row;
      outside_q <= !in_inside;
      acc       <= dither_mode ? SUM_W'(carry) : SUM_W'(0);
    end else if (acc_en) begin
      acc <= sum_total;
    end
    if (cmd.finish) begin
      smoothed <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dither_mode <= 1'b0;
      carry       <= '0;
      acc_en      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        dither_mode <= cfg_data;
      end
      if (cmd.clear_carry) begin
        carry <= '0;
      end else if (cmd.finish && dither_mode && !outside_q) begin
        carry <= sum_total[CARRY_W-1:0];
      end
      acc_en <= cmd.issue && tap_use;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_full = out_valid && !out_ready;

endmodule

/* design/dgs_checker.sv */
module dgs_checker import dgs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        opcode,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CELL_W-1:0] smoothed,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(smoothed))
    else $error("smoothed word changed or dropped while stalled");

  // a read occupies the block for its tap walk
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_READ |=> !in_ready ##1 !in_ready)
    else $error("word accepted during a read");

  // writes and clears leave the block ready for the next word
  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == OP_WRITE || opcode == OP_CLEAR) |=> in_ready)
    else $error("block busy after a write or clear");

  // no result leaves reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

  // config path never blocks
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind dithered_grid_smoothing_core dgs_checker u_chk (.*);

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dgs_pkg::*;

  // opcode three is dropped by the block, no constant for it in the package
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  // settle time after the last owed word, covers the tail of any read, write or clear
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned HOLD_OFF      = 300;

  typedef struct {
    int                col;
    int                row;
    logic [CELL_W-1:0] value;
  } smoothed_expect_t;

  // clock and reset
  logic clk;
  logic rst = 1'b1;

  // every block input is known from time zero
  logic              in_valid      = 1'b0;
  logic [1:0]        opcode        = OP_WRITE;
  logic [COL_W-1:0]  col           = '0;
  logic [ROW_W-1:0]  row           = '0;
  logic [CELL_W-1:0] cell_value    = '0;
  logic              out_ready     = 1'b0;
  logic              cfg_valid     = 1'b0;
  logic              dither_enable = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              cfg_ready;
  logic [CELL_W-1:0] smoothed;

  // shadow of the grid, the carry and the mode; grid and carry follow each accepted word, the mode each config write
  logic [CELL_W-1:0]  grid_shadow [MEM_DEPTH];
  bit                 cell_written [MEM_DEPTH];
  logic [CARRY_W-1:0] carry_shadow = '0;
  logic               dither_on    = 1'b0;

  // smoothed words still owed by the block, oldest first
  smoothed_expect_t expected_smoothed [$];

  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned in_idle_pct   = 8;
  int unsigned out_idle_pct  = 8;
  int unsigned rx_hold_cycles = 0;

  dithered_grid_smoothing_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .col          (col),
    .row          (row),
    .cell_value   (cell_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .smoothed     (smoothed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .dither_enable(dither_enable)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic logic [CELL_W-1:0] shadow_cell(input int c, input int r);
    return grid_shadow[r * GRID_WIDTH + c];
  endfunction

  // a read may only touch cells that have been written: the center and
  // every neighbor inside the grid (clamped neighbors are the center itself)
  function automatic bit neighborhood_written(input int c, input int r);
    return cell_written[r * GRID_WIDTH + c]
        && (c == 0 || cell_written[r * GRID_WIDTH + c - 1])
        && (c == GRID_WIDTH - 1 || cell_written[r * GRID_WIDTH + c + 1])
        && (r == 0 || cell_written[(r - 1) * GRID_WIDTH + c])
        && (r == GRID_HEIGHT - 1 || cell_written[(r + 1) * GRID_WIDTH + c]);
  endfunction

  // five-point smoothing of one cell; in dither mode the carry moves on
  function automatic logic [CELL_W-1:0] smooth_cell(input int c, input int r);
    logic [SUM_W-1:0] total;
    int cw, ce, rn, rs;
    if (dither_on) begin
      // edge neighbors clamp back onto the grid
      cw = (c > 0) ? c - 1 : c;
      ce = (c < GRID_WIDTH - 1) ? c + 1 : c;
      rn = (r > 0) ? r - 1 : r;
      rs = (r < GRID_HEIGHT - 1) ? r + 1 : r;
      total = shadow_cell(c, r) + shadow_cell(cw, r) + shadow_cell(ce, r)
            + shadow_cell(c, rn) + shadow_cell(c, rs) + carry_shadow;
      carry_shadow = total[CARRY_W-1:0];
    end else begin
      // missing neighbors count as zero, carry untouched
      total = shadow_cell(c, r);
      if (c > 0) total += shadow_cell(c - 1, r);
      if (c < GRID_WIDTH - 1) total += shadow_cell(c + 1, r);
      if (r > 0) total += shadow_cell(c, r - 1);
      if (r < GRID_HEIGHT - 1) total += shadow_cell(c, r + 1);
    end
    return ((total >> 2) > CELL_MAX) ? CELL_W'(CELL_MAX) : CELL_W'(total >> 2);
  endfunction

  // offer one word, hold it until taken, then update the shadow state
  task automatic send_word(input logic [1:0] op, input int c, input int r,
                           input logic [CELL_W-1:0] v);
    smoothed_expect_t exp_word;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    col        <= COL_W'(c);
    row        <= ROW_W'(r);
    cell_value <= v;
    do @(posedge clk); while (!in_ready);
    case (op)
      OP_WRITE: begin
        grid_shadow[r * GRID_WIDTH + c]  = v;
        cell_written[r * GRID_WIDTH + c] = 1'b1;
      end
      OP_READ: begin
        exp_word.col   = c;
        exp_word.row   = r;
        exp_word.value = smooth_cell(c, r);
        expected_smoothed.push_back(exp_word);
      end
      OP_CLEAR: carry_shadow = '0;
      default: ;
    endcase
    // dropped words do not count toward the stimulus amount
    if (op != OP_UNUSED) items_sent++;
  endtask

  // stop offering, let every owed word come back, then let the tail settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_smoothed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dither(input logic mode);
    wait_idle();
    cfg_valid     <= 1'b1;
    dither_enable <= mode;
    do @(posedge clk); while (!cfg_ready);
    dither_on = mode;
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, or a long counted hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // result checker: every taken word against the oldest expectation
  always @(posedge clk) begin
    smoothed_expect_t exp_word;
    if (!rst && out_valid && out_ready) begin
      if (expected_smoothed.size() == 0) begin
        note_failure($sformatf("smoothed word %0d with nothing expected", smoothed));
      end else begin
        exp_word = expected_smoothed.pop_front();
        if (smoothed !== exp_word.value)
          note_failure($sformatf("smoothed at col %0d row %0d: expected %0d got %0d",
                                 exp_word.col, exp_word.row, exp_word.value, smoothed));
      end
    end
  end

  function automatic int edge_biased_origin(input int span, input int size);
    case ($urandom_range(3))
      0:       return 0;
      1:       return span - size;
      default: return $urandom_range(span - size);
    endcase
  endfunction

  function automatic logic [CELL_W-1:0] patch_value(input int style);
    case (style)
      0:       return CELL_W'($urandom_range(CELL_MAX));
      1:       return CELL_W'($urandom_range(CELL_MAX, CELL_MAX - 31));
      2:       return CELL_W'($urandom_range(3));
      default: return $urandom_range(1) ? CELL_W'(CELL_MAX) : '0;
    endcase
  endfunction

  // stray word between the well-formed ones
  task automatic send_noise();
    int c, r;
    c = $urandom_range(GRID_WIDTH - 1);
    r = $urandom_range(GRID_HEIGHT - 1);
    case ($urandom_range(3))
      0: send_word(OP_UNUSED, c, r, CELL_W'($urandom));
      1: send_word(OP_WRITE, c, r, CELL_W'($urandom));
      2: send_word(OP_CLEAR, c, r, CELL_W'($urandom));
      default: begin
        if (neighborhood_written(c, r)) send_word(OP_READ, c, r, CELL_W'($urandom));
        else send_word(OP_WRITE, c, r, CELL_W'($urandom));
      end
    endcase
  endtask

  // plain mode: saturation, zero-padded corners, dropped opcode
  task automatic test_plain_edges();
    send_word(OP_WRITE, 0, 0, 8'hff);
    send_word(OP_WRITE, 1, 0, 8'hff);
    send_word(OP_WRITE, 0, 1, 8'hff);
    send_word(OP_WRITE, 1, 1, 8'hff);
    send_word(OP_WRITE, 2, 1, 8'hff);
    send_word(OP_WRITE, 1, 2, 8'hff);
    // all five at full scale, sum over 255 after the shift
    send_word(OP_READ, 1, 1, 8'h00);
    // corner with two neighbors missing
    send_word(OP_READ, 0, 0, 8'h00);
    send_word(OP_WRITE, GRID_WIDTH - 1, GRID_HEIGHT - 1, 8'h00);
    send_word(OP_WRITE, GRID_WIDTH - 2, GRID_HEIGHT - 1, 8'h01);
    send_word(OP_WRITE, GRID_WIDTH - 1, GRID_HEIGHT - 2, 8'h02);
    send_word(OP_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, 8'hff);
    // opcode three with every bit set must leave the cell alone
    send_word(OP_UNUSED, GRID_WIDTH - 1, GRID_HEIGHT - 1, 8'hff);
    send_word(OP_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, 8'hff);
    // clear in plain mode, carry is not used here anyway
    send_word(OP_CLEAR, 0, 0, 8'h00);
  endtask

  // dither mode: clamped edges, carry build-up and clear
  task automatic test_dither_edges();
    send_word(OP_READ, 0, 0, 8'h00);
    send_word(OP_READ, 1, 1, 8'h00);
    send_word(OP_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, 8'h00);
    send_word(OP_CLEAR, GRID_WIDTH - 1, GRID_HEIGHT - 1, 8'hff);
    send_word(OP_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, 8'h00);
    send_word(OP_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, 8'h00);
    send_word(OP_READ, 0, 0, 8'h00);
  endtask

  // receiver holds off long enough for the block to stall its input,
  // then the sender waits for every owed word before going on
  task automatic test_output_backpressure();
    in_idle_pct    = 0;
    rx_hold_cycles = HOLD_OFF;
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_word(OP_READ, 1, 1, CELL_W'($urandom));
        1: send_word(OP_READ, 0, 0, CELL_W'($urandom));
        2: send_word(OP_WRITE, 0, 1, CELL_W'($urandom));
        default: send_word(OP_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, CELL_W'($urandom));
      endcase
    end
    in_idle_pct = 8;
    wait_idle();
    for (int i = 0; i < 6; i++) send_word(OP_READ, 1, 1, CELL_W'($urandom));
  endtask

  // write a random patch, then read it back in serpentine order;
  // some patches are left with holes, stray words are mixed in
  task automatic test_random_patches(input int unsigned item_goal);
    int unsigned goal_mark;
    int w, h, c0, r0, style, c, r;
    bit holes;
    goal_mark = items_sent + item_goal;
    while (items_sent < goal_mark) begin
      w     = $urandom_range(6, 2);
      h     = $urandom_range(6, 2);
      c0    = edge_biased_origin(GRID_WIDTH, w);
      r0    = edge_biased_origin(GRID_HEIGHT, h);
      style = $urandom_range(3);
      holes = ($urandom_range(4) == 0);
      for (int i = 0; i < h; i++) begin
        for (int j = 0; j < w; j++) begin
          if (!(holes && $urandom_range(2) == 0))
            send_word(OP_WRITE, c0 + j, r0 + i, patch_value(style));
          if ($urandom_range(9) == 0) send_noise();
        end
      end
      if ($urandom_range(2) == 0) send_word(OP_CLEAR, c0, r0, CELL_W'($urandom));
      for (int i = 0; i < h; i++) begin
        for (int j = 0; j < w; j++) begin
          r = r0 + i;
          c = (i % 2 == 0) ? c0 + j : c0 + w - 1 - j;
          if (neighborhood_written(c, r)) send_word(OP_READ, c, r, CELL_W'($urandom));
          if ($urandom_range(9) == 0) send_noise();
        end
      end
    end
  endtask

  // long stretch with no idling on either side
  task automatic test_unbroken_stream(input int unsigned item_goal);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_patches(item_goal);
    in_idle_pct  = 8;
    out_idle_pct = 8;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_dither(1'b0);
    test_plain_edges();
    set_dither(1'b1);
    test_dither_edges();
    test_output_backpressure();
    set_dither(1'b0);
    test_random_patches(350);
    set_dither(1'b1);
    test_random_patches(350);
    test_unbroken_stream(250);
    set_dither(1'b0);
    test_random_patches(300);
    wait_idle();
    if (fail_count == 0 && expected_smoothed.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* dithered_grid_smoothing_core.f */
design/dgs_pkg.sv
design/dgs_ctrl.sv
design/dgs_datapath.sv
design/dithered_grid_smoothing_core.sv
design/dgs_checker.sv
tb/testbench.sv
